@@ sv/dwq_pkg.sv @@
// ----------------------------------------------------------------------------
// dwq_pkg: shared types and constants for the deferred work queue
// Command codes, importance levels, stream field layout, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dwq_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IMP_W  = 2;
  localparam int unsigned WORD_W = 64;

  // slave-side tdata layout
  localparam int unsigned IN_DATA_W    = 144;
  localparam int unsigned IN_SLOT_LSB  = 0;
  localparam int unsigned IN_IMP_LSB   = 6;
  localparam int unsigned IN_A_LSB     = 8;
  localparam int unsigned IN_B_LSB     = 72;
  localparam int unsigned IN_LOCAL_BIT = 136;

  // master-side tdata layout
  localparam int unsigned OUT_DATA_W    = 144;
  localparam int unsigned OUT_ACC_BIT   = 0;
  localparam int unsigned OUT_EMPTY_BIT = 1;
  localparam int unsigned OUT_SLOT_LSB  = 2;
  localparam int unsigned OUT_A_LSB     = 8;
  localparam int unsigned OUT_B_LSB     = 72;
  localparam int unsigned OUT_DISP_BIT  = 136;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 3'd0,
    MODE_SET_IMP = 3'd1,
    MODE_INSERT  = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_POP     = 3'd4
  } mode_t;

  typedef logic [IMP_W-1:0] imp_t;
  localparam imp_t IMP_LOW    = 2'd0;
  localparam imp_t IMP_MEDIUM = 2'd1;
  localparam imp_t IMP_HIGH   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_LINK,
    ST_WALK,
    ST_WALK_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic look;
    logic exec;
    logic link;
    logic walk_rd;
    logic walk_chk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_link;
    logic need_walk;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

@@ sv/deferred_work_queue.sv @@
// ----------------------------------------------------------------------------
// deferred_work_queue: linked queue of deferred work slots
// Commands arrive on the slave stream (s_tuser carries the command code),
// one result per command leaves on the master stream.
// Usage:
//   Init, set-importance, insert, remove and pop each return one result item.
//   Insert links at the head for high importance or an empty queue, else at
//   the tail. Pop returns the head slot and its two argument words.
// Timing:
//   One command at a time. Init, set-importance, head insert and pop step
//   through lookup, execute and result hand-off before m_tvalid rises; a tail
//   insert adds a link step, set by the single write port of the link memory.
//   Remove walks the list with a read and a check step per link to its slot.
// Reset:
//   rst empties the queue, then a clearing pass resets every slot to
//   unqueued, medium importance; s_tready stays low meanwhile.
// Stall:
//   The result sits in an output register; the next command is accepted
//   while it waits, and its own result holds until the register is free.
// ----------------------------------------------------------------------------
module deferred_work_queue #(
  parameter int unsigned NUM_SLOTS = 64,
  parameter int unsigned ARG_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot[5:0], importance_in[7:6], arg_a[71:8], arg_b[135:72],
  // from_local[136], zero pad[143:137]
  input  logic [dwq_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode[2:0]
  input  logic [dwq_pkg::MODE_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // accepted[0], queue_empty[1], popped_slot[7:2], popped_arg_a[71:8],
  // popped_arg_b[135:72], dispatch_request[136], zero pad[143:137]
  output logic [dwq_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import dwq_pkg::*;

  cmd_t              cmd;
  status_t           status;
  mode_t             mode_in;
  logic [SLOT_W-1:0] slot_in;
  imp_t              imp_in;
  logic [WORD_W-1:0] arg_a_in;
  logic [WORD_W-1:0] arg_b_in;
  logic              local_in;

  assign mode_in  = mode_t'(s_tuser);
  assign slot_in  = s_tdata[IN_SLOT_LSB +: SLOT_W];
  assign imp_in   = s_tdata[IN_IMP_LSB +: IMP_W];
  assign arg_a_in = s_tdata[IN_A_LSB +: WORD_W];
  assign arg_b_in = s_tdata[IN_B_LSB +: WORD_W];
  assign local_in = s_tdata[IN_LOCAL_BIT];

  dwq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dwq_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .ARG_WIDTH (ARG_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .mode_in  (mode_in),
    .slot_in  (slot_in),
    .imp_in   (imp_in),
    .arg_a_in (arg_a_in),
    .arg_b_in (arg_b_in),
    .local_in (local_in),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in progress");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  a_acc_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[OUT_ACC_BIT] && m_tdata[OUT_EMPTY_BIT]))
    else $error("result both accepted and empty");

  a_disp_acc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_DISP_BIT]) |-> m_tdata[OUT_ACC_BIT])
    else $error("dispatch request on a refused command");
`endif

endmodule

@@ sv/dwq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dwq_ctrl: sequencer of the deferred work queue
// Steps each item through lookup, execute, optional tail link or list walk,
// and result hand-off; runs the slot table clearing pass after reset.
// ----------------------------------------------------------------------------
module dwq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  dwq_pkg::status_t status,
  output dwq_pkg::cmd_t    cmd
);
  import dwq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:     if (s_tvalid) state_next = ST_LOOK;
      ST_LOOK:     state_next = ST_EXEC;
      ST_EXEC: begin
        if (status.need_link) begin
          state_next = ST_LINK;
        end else if (status.need_walk) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LINK:     state_next = ST_DONE;
      ST_WALK:     state_next = ST_WALK_CHK;
      ST_WALK_CHK: state_next = status.walk_done ? ST_DONE : ST_WALK;
      ST_DONE:     if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      ST_CLEAR:    cmd.clear = 1'b1;
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_LOOK:     cmd.look = 1'b1;
      ST_EXEC:     cmd.exec = 1'b1;
      ST_LINK:     cmd.link = 1'b1;
      ST_WALK:     cmd.walk_rd = 1'b1;
      ST_WALK_CHK: cmd.walk_chk = 1'b1;
      ST_DONE:     cmd.load_out = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

@@ sv/dwq_datapath.sv @@
// ----------------------------------------------------------------------------
// dwq_datapath: slot tables, queue pointers and result register
// Holds per-slot state, next links and arguments in memories, the head and
// tail pointers, the list walk registers and the output register.
// ----------------------------------------------------------------------------
module dwq_datapath #(
  parameter int unsigned NUM_SLOTS = 64,
  parameter int unsigned ARG_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dwq_pkg::cmd_t                cmd,
  output dwq_pkg::status_t             status,
  input  dwq_pkg::mode_t               mode_in,
  input  logic [dwq_pkg::SLOT_W-1:0]   slot_in,
  input  dwq_pkg::imp_t                imp_in,
  input  logic [dwq_pkg::WORD_W-1:0]   arg_a_in,
  input  logic [dwq_pkg::WORD_W-1:0]   arg_b_in,
  input  logic                         local_in,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dwq_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dwq_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam int unsigned PTR_W = $clog2(NUM_SLOTS + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef struct packed {
    logic queued;
    imp_t imp;
  } info_t;

  info_t                info_mem [NUM_SLOTS];
  logic [PTR_W-1:0]     link_mem [NUM_SLOTS];
  logic [ARG_WIDTH-1:0] arga_mem [NUM_SLOTS];
  logic [ARG_WIDTH-1:0] argb_mem [NUM_SLOTS];

  // captured item
  mode_t                c_mode;
  logic [IDX_W-1:0]     c_slot;
  logic                 c_in_range;
  imp_t                 c_imp;
  logic [ARG_WIDTH-1:0] c_a;
  logic [ARG_WIDTH-1:0] c_b;
  logic                 c_local;

  logic [PTR_W-1:0]     head, head_next;
  logic [PTR_W-1:0]     tail, tail_next;
  logic [PTR_W-1:0]     cur, cur_next;
  logic [PTR_W-1:0]     prev, prev_next;
  logic [IDX_W-1:0]     clr_idx;

  info_t                info_q;
  logic [PTR_W-1:0]     link_q;
  logic [ARG_WIDTH-1:0] arga_q;
  logic [ARG_WIDTH-1:0] argb_q;

  logic                 res_acc, res_acc_next;
  logic                 res_empty, res_empty_next;
  logic                 res_disp, res_disp_next;
  logic                 res_pop, res_pop_next;
  logic [SLOT_W-1:0]    res_slot, res_slot_next;

  logic                 info_we;
  logic [IDX_W-1:0]     info_wa;
  info_t                info_wd;
  logic                 link_we;
  logic [IDX_W-1:0]     link_wa;
  logic [PTR_W-1:0]     link_wd;
  logic                 arg_we;
  logic [IDX_W-1:0]     info_ra;
  logic [IDX_W-1:0]     link_ra;
  logic                 link_re;

  logic [PTR_W-1:0]     s_ptr;
  logic                 head_null;
  logic                 cur_null;
  logic                 link_null;
  logic                 hit;
  logic [OUT_DATA_W-1:0] out_word;

  assign s_ptr     = PTR_W'(c_slot);
  assign head_null = (head == NULL_PTR);
  assign cur_null  = (cur == NULL_PTR);
  assign link_null = (link_q == NULL_PTR);
  assign hit       = (cur == s_ptr);

  // pop looks at the head entry, every other command at its own slot
  assign info_ra = (c_mode == MODE_POP) ? IDX_W'(head) : c_slot;
  assign link_ra = cmd.walk_rd ? IDX_W'(cur) : IDX_W'(head);
  assign link_re = cmd.look || (cmd.walk_rd && !cur_null);

  assign status.clear_last = (clr_idx == LAST_IDX);
  assign status.need_link  = (c_mode == MODE_INSERT) && c_in_range && !info_q.queued &&
                             !head_null && (info_q.imp != IMP_HIGH);
  assign status.need_walk  = (c_mode == MODE_REMOVE) && c_in_range && info_q.queued;
  assign status.walk_done  = hit || cur_null;
  assign status.out_free   = !m_tvalid || m_tready;

  always_comb begin
    info_we        = 1'b0;
    info_wa        = c_slot;
    info_wd        = info_q;
    link_we        = 1'b0;
    link_wa        = c_slot;
    link_wd        = NULL_PTR;
    arg_we         = 1'b0;
    head_next      = head;
    tail_next      = tail;
    cur_next       = cur;
    prev_next      = prev;
    res_acc_next   = res_acc;
    res_empty_next = res_empty;
    res_disp_next  = res_disp;
    res_pop_next   = res_pop;
    res_slot_next  = res_slot;

    if (cmd.clear) begin
      info_we = 1'b1;
      info_wa = clr_idx;
      info_wd = '{queued: 1'b0, imp: IMP_MEDIUM};
    end

    if (cmd.capture) begin
      res_acc_next   = 1'b0;
      res_empty_next = 1'b0;
      res_disp_next  = 1'b0;
      res_pop_next   = 1'b0;
      res_slot_next  = '0;
    end

    if (cmd.exec) begin
      case (c_mode)
        MODE_INIT: begin
          if (c_in_range && !info_q.queued) begin
            info_we      = 1'b1;
            info_wd      = '{queued: 1'b0, imp: IMP_MEDIUM};
            res_acc_next = 1'b1;
          end
        end
        MODE_SET_IMP: begin
          if (c_in_range && (c_imp <= IMP_HIGH)) begin
            info_we      = 1'b1;
            info_wd.imp  = c_imp;
            res_acc_next = 1'b1;
          end
        end
        MODE_INSERT: begin
          if (c_in_range && !info_q.queued) begin
            arg_we         = 1'b1;
            info_we        = 1'b1;
            info_wd.queued = 1'b1;
            res_acc_next   = 1'b1;
            res_disp_next  = c_local;
            link_we        = 1'b1;
            if (head_null) begin
              head_next = s_ptr;
              tail_next = s_ptr;
            end else if (info_q.imp == IMP_HIGH) begin
              link_wd   = head;
              head_next = s_ptr;
            end else begin
              // chain behind the old tail; the slot's own end mark follows
              link_wa = IDX_W'(tail);
              link_wd = s_ptr;
            end
          end
        end
        MODE_REMOVE: begin
          if (status.need_walk) begin
            cur_next  = head;
            prev_next = NULL_PTR;
          end
        end
        MODE_POP: begin
          if (!head_null) begin
            info_we        = 1'b1;
            info_wa        = IDX_W'(head);
            info_wd.queued = 1'b0;
            head_next      = link_null ? NULL_PTR : link_q;
            if (link_null) tail_next = NULL_PTR;
            res_acc_next   = 1'b1;
            res_pop_next   = 1'b1;
            res_slot_next  = SLOT_W'(head);
          end else begin
            res_empty_next = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.link) begin
      link_we   = 1'b1;
      tail_next = s_ptr;
    end

    if (cmd.walk_chk) begin
      if (hit) begin
        if (prev == NULL_PTR) begin
          head_next = link_q;
        end else begin
          link_we = 1'b1;
          link_wa = IDX_W'(prev);
          link_wd = link_q;
        end
        if (tail == s_ptr) tail_next = prev;
        info_we        = 1'b1;
        info_wd.queued = 1'b0;
        res_acc_next   = 1'b1;
      end else if (!cur_null) begin
        // advance one link
        prev_next = cur;
        cur_next  = link_q;
      end
    end
  end

  always_comb begin
    out_word                            = '0;
    out_word[OUT_ACC_BIT]               = res_acc;
    out_word[OUT_EMPTY_BIT]             = res_empty;
    out_word[OUT_SLOT_LSB +: SLOT_W]    = res_slot;
    out_word[OUT_DISP_BIT]              = res_disp;
    if (res_pop) begin
      out_word[OUT_A_LSB +: WORD_W] = WORD_W'(arga_q);
      out_word[OUT_B_LSB +: WORD_W] = WORD_W'(argb_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NULL_PTR;
      tail     <= NULL_PTR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_mode     <= mode_in;
      c_slot     <= IDX_W'(slot_in);
      c_in_range <= (32'(slot_in) < NUM_SLOTS);
      c_imp      <= imp_in;
      c_a        <= ARG_WIDTH'(arg_a_in);
      c_b        <= ARG_WIDTH'(arg_b_in);
      c_local    <= local_in;
    end
    cur       <= cur_next;
    prev      <= prev_next;
    res_acc   <= res_acc_next;
    res_empty <= res_empty_next;
    res_disp  <= res_disp_next;
    res_pop   <= res_pop_next;
    res_slot  <= res_slot_next;
    if (cmd.load_out) m_tdata <= out_word;
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (cmd.look) info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (arg_we) begin
      arga_mem[c_slot] <= c_a;
      argb_mem[c_slot] <= c_b;
    end
    if (cmd.look) begin
      arga_q <= arga_mem[IDX_W'(head)];
      argb_q <= argb_mem[IDX_W'(head)];
    end
  end

endmodule
